// ----- design/hlbc_pkg.sv -----
package hlbc_pkg;

   localparam int BLOCK_W = 32;
   localparam int SLOT_W  = 5;
   localparam logic [7:0] MAX_COUNT = 8'd255;

   localparam logic [1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_PIN     = 2'd2;
   localparam logic [1:0] REQ_UNPIN   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_ZERO    = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         device_id;
      logic [BLOCK_W-1:0] block_number;
      logic [SLOT_W-1:0]  buffer_index;
   } req_beat_type;

   typedef struct packed {
      logic [SLOT_W-1:0] buffer_slot;
      logic              was_hit;
      logic              needs_disk_read;
      logic [1:0]        status;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0]         dev;
      logic [BLOCK_W-1:0] blk;
      logic [7:0]         cnt;
      logic               valid;
   } buf_entry_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_IDXRED,
      ST_BUF,
      ST_RELHOME,
      ST_HOME,
      ST_HIT_HDR,
      ST_HIT_CHK,
      ST_MISS_HDR,
      ST_MISS_CHK,
      ST_U_RDP,
      ST_U_WRP,
      ST_U_RDN,
      ST_U_WRN,
      ST_H_RD,
      ST_H_WRB,
      ST_F_RD,
      ST_F_WR,
      ST_H_RD2,
      ST_H_WR,
      ST_DONE
   } state_type;

endpackage

// ----- design/hashed_lru_block_buffer_cache.sv -----
// Buffer cache directory with hashed, LRU-ordered bucket lists.
// Request channel (req_valid/req_ready/req_data) takes one beat per
// operation: acquire, release, pin or unpin. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one beat per request,
// in order, from an output register.
// One request is worked at a time. Pin and unpin first fold buffer_index
// into range by subtracting NUM_BUFFERS (ST_IDXRED), then read the
// buffer (ST_BUF) and present their beat from ST_DONE.
// Acquire first computes the home bucket (a remainder unit that folds
// one byte of the block number per cycle), then reads bucket heads and
// buffers along the lists, since each step issues the next read from
// the link just returned. A miss adds link updates that unlink the
// buffer and put it at the head of its home list; a release that drops
// a count to zero recomputes its home bucket and makes those updates.
// After reset the block sweeps the link and buffer memories, one node
// per cycle, all NUM_BUFFERS + NUM_BUCKETS nodes, with req_ready low.
// A stalled receiver holds the response; the next request is still
// taken and worked, and its result waits until the held beat leaves.
module hashed_lru_block_buffer_cache #(
   parameter int NUM_BUFFERS = 32,
   parameter int NUM_BUCKETS = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hlbc_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output hlbc_pkg::rsp_beat_type rsp_data
);
   import hlbc_pkg::*;

   localparam int NODE_COUNT = NUM_BUFFERS + NUM_BUCKETS;
   localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int KW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int NW = $clog2(NODE_COUNT);
   localparam logic [NW-1:0] NBN = NW'(NUM_BUFFERS);

   typedef struct packed {
      logic [NW-1:0] nxt;
      logic [NW-1:0] prv;
   } link_type;

   state_type     state_ff, state_in;
   req_beat_type  req_ff, req_in;
   rsp_beat_type  res_ff, res_in;
   rsp_beat_type  rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] p_ff, p_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] first_ff, first_in;
   logic [NW-1:0] init_ff, init_in;
   logic [KW-1:0] home_ff, home_in;
   logic [KW-1:0] bkt_ff, bkt_in;
   logic [SLOT_W-1:0] red_ff, red_in;

   buf_entry_type buf_mem [NUM_BUFFERS];
   buf_entry_type brd_ff;
   logic          buf_we;
   logic [BW-1:0] buf_waddr, buf_raddr;
   buf_entry_type buf_wdata;

   link_type      lnk_mem [NODE_COUNT];
   link_type      lrd_ff;
   logic          lnk_we;
   logic [NW-1:0] lnk_waddr, lnk_raddr;
   link_type      lnk_wdata;

   logic               rem_start, rem_busy;
   logic [BLOCK_W-1:0] rem_dividend;
   logic [KW-1:0]      rem_value;

   hlbc_rem #(.DIVISOR(NUM_BUCKETS), .KW(KW)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .busy     (rem_busy),
      .rem      (rem_value)
   );

   function automatic logic [NW-1:0] head_node(input logic [KW-1:0] b);
      return NBN + NW'(b);
   endfunction

   function automatic logic [KW-1:0] bkt_wrap(input logic [KW-1:0] b);
      logic [KW-1:0] r;
      if (int'(b) == NUM_BUCKETS - 1) begin
         r = '0;
      end else begin
         r = b + 1'b1;
      end
      return r;
   endfunction

   function automatic link_type reset_link(input logic [NW-1:0] i);
      link_type l;
      if (i < NBN) begin
         l.nxt = (i == '0) ? NBN : i - 1'b1;
         l.prv = (i == NBN - 1'b1) ? NBN : i + 1'b1;
      end else if (i == NBN) begin
         l.nxt = NBN - 1'b1;
         l.prv = '0;
      end else begin
         l.nxt = i;
         l.prv = i;
      end
      return l;
   endfunction

   always_comb begin
      logic [NW-1:0] nd;
      logic [KW-1:0] nb;
      logic          walk_end;
      logic          hit_walk;
      buf_entry_type upd;

      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      node_in      = node_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      first_in     = first_ff;
      init_in      = init_ff;
      home_in      = home_ff;
      bkt_in       = bkt_ff;
      red_in       = red_ff;
      buf_we       = 1'b0;
      buf_waddr    = node_ff[BW-1:0];
      buf_raddr    = '0;
      buf_wdata    = brd_ff;
      lnk_we       = 1'b0;
      lnk_waddr    = '0;
      lnk_raddr    = '0;
      lnk_wdata    = lrd_ff;
      rem_start    = 1'b0;
      rem_dividend = req_data.block_number;
      req_ready    = 1'b0;
      nd           = '0;
      nb           = '0;
      walk_end     = 1'b0;
      hit_walk     = 1'b0;
      upd          = brd_ff;

      case (state_ff)
         ST_INIT: begin
            lnk_we    = 1'b1;
            lnk_waddr = init_ff;
            lnk_wdata = reset_link(init_ff);
            if (init_ff < NBN) begin
               buf_we    = 1'b1;
               buf_waddr = init_ff[BW-1:0];
               buf_wdata = '0;
            end
            if (init_ff == NW'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               red_in = req_data.buffer_index;
               if (req_data.req_type == REQ_ACQUIRE) begin
                  rem_start = 1'b1;
                  state_in  = ST_HOME;
               end else begin
                  state_in = ST_IDXRED;
               end
            end
         end
         ST_IDXRED: begin
            if (int'(red_ff) >= NUM_BUFFERS) begin
               red_in = red_ff - SLOT_W'(NUM_BUFFERS);
            end else begin
               node_in   = NW'(red_ff);
               buf_raddr = BW'(red_ff);
               lnk_raddr = NW'(red_ff);
               state_in  = ST_BUF;
            end
         end
         ST_BUF: begin
            res_in = '{buffer_slot: SLOT_W'(node_ff[BW-1:0]), was_hit: 1'b0,
                       needs_disk_read: 1'b0, status: STATUS_OK};
            state_in = ST_DONE;
            if (req_ff.req_type == REQ_PIN) begin
               if (brd_ff.cnt != MAX_COUNT) begin
                  upd.cnt = brd_ff.cnt + 1'b1;
               end
               buf_we    = 1'b1;
               buf_wdata = upd;
            end else if (brd_ff.cnt == '0) begin
               res_in.status = STATUS_ZERO;
            end else begin
               upd.cnt   = brd_ff.cnt - 1'b1;
               buf_we    = 1'b1;
               buf_wdata = upd;
               if (req_ff.req_type == REQ_RELEASE && brd_ff.cnt == 8'd1) begin
                  p_in         = lrd_ff.prv;
                  n_in         = lrd_ff.nxt;
                  rem_start    = 1'b1;
                  rem_dividend = brd_ff.blk;
                  state_in     = ST_RELHOME;
               end
            end
         end
         ST_RELHOME: begin
            if (!rem_busy) begin
               home_in  = rem_value;
               state_in = ST_U_RDP;
            end
         end
         ST_HOME: begin
            if (!rem_busy) begin
               home_in   = rem_value;
               lnk_raddr = head_node(rem_value);
               state_in  = ST_HIT_HDR;
            end
         end
         ST_HIT_HDR, ST_HIT_CHK: begin
            hit_walk = 1'b1;
            if (state_ff == ST_HIT_CHK && brd_ff.dev == req_ff.device_id &&
                brd_ff.blk == req_ff.block_number) begin
               if (brd_ff.cnt != MAX_COUNT) begin
                  upd.cnt = brd_ff.cnt + 1'b1;
               end
               upd.valid = 1'b1;
               buf_we    = 1'b1;
               buf_wdata = upd;
               res_in = '{buffer_slot: SLOT_W'(node_ff[BW-1:0]), was_hit: 1'b1,
                          needs_disk_read: !brd_ff.valid, status: STATUS_OK};
               state_in = ST_DONE;
            end else begin
               nd = lrd_ff.nxt;
               if (nd < NBN) begin
                  node_in   = nd;
                  buf_raddr = nd[BW-1:0];
                  lnk_raddr = nd;
                  state_in  = ST_HIT_CHK;
               end else begin
                  walk_end = 1'b1;
               end
            end
         end
         ST_MISS_HDR, ST_MISS_CHK: begin
            if (state_ff == ST_MISS_CHK && brd_ff.cnt == '0) begin
               buf_we    = 1'b1;
               buf_wdata = '{dev: req_ff.device_id, blk: req_ff.block_number,
                             cnt: 8'd1, valid: 1'b1};
               p_in   = lrd_ff.prv;
               n_in   = lrd_ff.nxt;
               res_in = '{buffer_slot: SLOT_W'(node_ff[BW-1:0]), was_hit: 1'b0,
                          needs_disk_read: 1'b1, status: STATUS_OK};
               state_in = ST_U_RDP;
            end else begin
               nd = lrd_ff.prv;
               if (nd < NBN) begin
                  node_in   = nd;
                  buf_raddr = nd[BW-1:0];
                  lnk_raddr = nd;
                  state_in  = ST_MISS_CHK;
               end else begin
                  walk_end = 1'b1;
               end
            end
         end
         ST_U_RDP: begin
            lnk_raddr = p_ff;
            state_in  = ST_U_WRP;
         end
         ST_U_WRP: begin
            lnk_we    = 1'b1;
            lnk_waddr = p_ff;
            lnk_wdata = '{nxt: n_ff, prv: lrd_ff.prv};
            state_in  = ST_U_RDN;
         end
         ST_U_RDN: begin
            lnk_raddr = n_ff;
            state_in  = ST_U_WRN;
         end
         ST_U_WRN: begin
            lnk_we    = 1'b1;
            lnk_waddr = n_ff;
            lnk_wdata = '{nxt: lrd_ff.nxt, prv: p_ff};
            state_in  = ST_H_RD;
         end
         ST_H_RD: begin
            lnk_raddr = head_node(home_ff);
            state_in  = ST_H_WRB;
         end
         ST_H_WRB: begin
            first_in  = lrd_ff.nxt;
            lnk_we    = 1'b1;
            lnk_waddr = node_ff;
            lnk_wdata = '{nxt: lrd_ff.nxt, prv: head_node(home_ff)};
            state_in  = ST_F_RD;
         end
         ST_F_RD: begin
            lnk_raddr = first_ff;
            state_in  = ST_F_WR;
         end
         ST_F_WR: begin
            lnk_we    = 1'b1;
            lnk_waddr = first_ff;
            lnk_wdata = '{nxt: lrd_ff.nxt, prv: node_ff};
            state_in  = ST_H_RD2;
         end
         ST_H_RD2: begin
            lnk_raddr = head_node(home_ff);
            state_in  = ST_H_WR;
         end
         ST_H_WR: begin
            lnk_we    = 1'b1;
            lnk_waddr = head_node(home_ff);
            lnk_wdata = '{nxt: node_ff, prv: lrd_ff.prv};
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A list ran out: move to the next bucket after the current one.
      // Coming back around to home means no idle buffer was found outside home.
      if (walk_end) begin
         nb = bkt_wrap(hit_walk ? home_ff : bkt_ff);
         if (nb == home_ff) begin
            res_in = '{buffer_slot: '0, was_hit: 1'b0, needs_disk_read: 1'b0,
                       status: STATUS_NO_FREE};
            state_in = ST_DONE;
         end else begin
            bkt_in    = nb;
            lnk_raddr = head_node(nb);
            state_in  = ST_MISS_HDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      node_ff     <= node_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      first_ff    <= first_in;
      home_ff     <= home_in;
      bkt_ff      <= bkt_in;
      red_ff      <= red_in;
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      brd_ff <= buf_mem[buf_raddr];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_waddr] <= lnk_wdata;
      end
      lrd_ff <= lnk_mem[lnk_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_hit |-> rsp_data.status == STATUS_OK)
      else $error("hit beat carries an error status");

   a_idle_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rem_busy)
      else $error("remainder unit busy while idle");

   a_lnk_addr: assert property (@(posedge clock) disable iff (reset)
      lnk_we |-> int'(lnk_waddr) < NODE_COUNT)
      else $error("link write beyond node range");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");
`endif

endmodule

// ----- design/hlbc_rem.sv -----
module hlbc_rem #(
   parameter int DIVISOR = 13,
   parameter int KW      = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hlbc_pkg::BLOCK_W-1:0] dividend,
   output logic                        busy,
   output logic [KW-1:0]               rem
);
   import hlbc_pkg::*;

   localparam int STEPS = BLOCK_W / 8;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [BLOCK_W-1:0] shift_ff, shift_in;
   logic [KW-1:0]      r_ff, r_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [KW:0]        sum;

   // Residue tables: a byte value modulo the divisor, and a partial
   // remainder shifted up by one byte, modulo the divisor.
   logic [255:0][KW-1:0]     byte_mod;
   logic [2**KW-1:0][KW-1:0] scaled_mod;

   for (genvar g = 0; g < 256; g++) begin : g_byte
      assign byte_mod[g] = KW'(g % DIVISOR);
   end

   for (genvar g = 0; g < 2**KW; g++) begin : g_scaled
      assign scaled_mod[g] = KW'((g * 256) % DIVISOR);
   end

   // One byte of the dividend per cycle from the top. Both residues are
   // below the divisor, so a single compare and subtract finishes a step.
   always_comb begin
      sum = {1'b0, scaled_mod[r_ff]} + {1'b0, byte_mod[shift_ff[BLOCK_W-1 -: 8]]};
      if (sum >= (KW+1)'(DIVISOR)) begin
         sum = sum - (KW+1)'(DIVISOR);
      end
      shift_in = shift_ff;
      r_in     = r_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         shift_in = dividend;
         r_in     = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[BLOCK_W-9:0], 8'd0};
         r_in     = sum[KW-1:0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      shift_ff <= shift_in;
      r_ff     <= r_in;
      cnt_ff   <= cnt_in;
   end

   assign busy = busy_ff;
   assign rem  = r_ff;

endmodule
